// ===== hdl/bnm_pkg.sv =====
// ----------------------------------------------------------------------------
// bnm_pkg
// Shared constants, types and helpers for the bass to periodic noise mover.
// ----------------------------------------------------------------------------
package bnm_pkg;

    localparam int CHANNELS    = 8;
    localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W       = $clog2(CHANNELS + 1);
    localparam int STORE_DEPTH = 2 * (2 ** IDX_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int WORD_W = 20;
    localparam int VOL_W  = 8;
    localparam int CHAN_W = 4;
    localparam int TONE_W = 12;

    localparam logic [TONE_W-1:0] BASS_LIMIT     = 12'h3ff;
    localparam logic [WORD_W-1:0] PERIODIC_FLAG  = 20'h20000;
    localparam logic [WORD_W-1:0] TRIGGER_FLAG   = 20'h10000;
    localparam logic [WORD_W-1:0] SILENT_WORD    = 20'h00001;
    localparam logic [TONE_W-1:0] TONE_ONE       = 12'h001;
    localparam logic [3:0]        BASS_SAT       = 4'd15;
    localparam logic [3:0]        CONFLICT_MIN   = 4'd2;

    // (tone + 7) / 15 as a multiply by 2^19/15 rounded up, then shift by 19
    localparam int                ROUND_BIAS  = 7;
    localparam int                SUM_W       = 13;
    localparam int                RECIP_W     = 16;
    localparam int                PROD_W      = SUM_W + RECIP_W;
    localparam int                RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_15   = 16'h8889;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ENTRY,
        BK_NOISE
    } back_state_t;

    typedef struct packed {
        logic              bank;
        logic [CNT_W-1:0]  count;
        logic              found;
        logic [IDX_W-1:0]  loud_idx;
        logic [VOL_W-1:0]  loud_vol;
        logic [TONE_W-1:0] noise_tone;
        logic              conflict;
    } row_desc_t;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] word;
        logic [VOL_W-1:0]  vol;
    } store_wr_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

    function automatic logic is_bass_word(input logic [WORD_W-1:0] w);
        return (w[19:16] == 4'd0) && (w[TONE_W-1:0] > BASS_LIMIT);
    endfunction

endpackage

// ===== hdl/bnm_in_if.sv =====
// ----------------------------------------------------------------------------
// bnm_in_if
// Channel entry input channel: valid/ready plus one entry word.
// ----------------------------------------------------------------------------
interface bnm_in_if;
    import bnm_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] channel_word;
    logic [VOL_W-1:0]  channel_volume;
    logic              row_end;

    modport source (output valid, output channel_word, output channel_volume,
                    output row_end, input ready);
    modport sink   (input valid, input channel_word, input channel_volume,
                    input row_end, output ready);
endinterface

// ===== hdl/bnm_out_if.sv =====
// ----------------------------------------------------------------------------
// bnm_out_if
// Result channel: valid/ready plus one output channel entry.
// ----------------------------------------------------------------------------
interface bnm_out_if;
    import bnm_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_channel;
    logic [WORD_W-1:0] out_word;
    logic [VOL_W-1:0]  out_volume;
    logic              row_done;

    modport source (output valid, output out_channel, output out_word,
                    output out_volume, output row_done, input ready);
    modport sink   (input valid, input out_channel, input out_word,
                    input out_volume, input row_done, output ready);
endinterface

// ===== hdl/bnm_front.sv =====
// ----------------------------------------------------------------------------
// bnm_front
// Accepts entries, tracks bass count and loudest bass, writes the row store
// and pushes one row descriptor per row.
// ----------------------------------------------------------------------------
module bnm_front (
    input  logic                clk,
    input  logic                rst_n,
    bnm_in_if.sink              items,
    input  logic                q_full,
    input  bnm_pkg::bank_rel_t  release_bank,
    output bnm_pkg::store_wr_t  store_wr,
    output logic                push,
    output bnm_pkg::row_desc_t  push_desc
);
    import bnm_pkg::*;

    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [VOL_W-1:0]  level_reg, level_next;
    logic [IDX_W-1:0]  loud_idx_reg, loud_idx_next;
    logic [TONE_W-1:0] loud_tone_reg, loud_tone_next;
    logic [3:0]        bass_cnt_reg, bass_cnt_next;
    logic              bank_reg, bank_next;
    logic [1:0]        busy_reg, busy_next;

    logic              accept;
    logic              take;
    logic              bass;
    logic              louder;
    logic              end_row;
    logic [SUM_W-1:0]  tone_sum;
    logic [PROD_W-1:0] prod;

    assign items.ready = !busy_reg[bank_reg] && !q_full;
    assign accept      = items.valid && items.ready;
    assign take        = accept && (fill_reg < CNT_W'(CHANNELS));
    assign bass        = is_bass_word(items.channel_word) && (items.channel_volume != '0);
    assign louder      = take && bass && (items.channel_volume > level_reg);
    assign end_row     = accept && items.row_end;

    always_comb
    begin
        fill_next      = take ? fill_reg + CNT_W'(1) : fill_reg;
        bass_cnt_next  = (take && bass && bass_cnt_reg != BASS_SAT) ?
                         bass_cnt_reg + 4'd1 : bass_cnt_reg;
        level_next     = louder ? items.channel_volume : level_reg;
        loud_idx_next  = louder ? fill_reg[IDX_W-1:0] : loud_idx_reg;
        loud_tone_next = louder ? items.channel_word[TONE_W-1:0] : loud_tone_reg;
    end

    // noise tone from the loudest bass tone, including the entry taken now
    assign tone_sum = SUM_W'(loud_tone_next) + SUM_W'(ROUND_BIAS);
    assign prod     = PROD_W'(tone_sum) * PROD_W'(RECIP_15);

    always_comb
    begin
        push_desc.bank       = bank_reg;
        push_desc.count      = fill_next;
        push_desc.found      = (level_next != '0);
        push_desc.loud_idx   = loud_idx_next;
        push_desc.loud_vol   = level_next;
        push_desc.noise_tone = TONE_W'(prod >> RECIP_SHIFT);
        push_desc.conflict   = (bass_cnt_next >= CONFLICT_MIN);
    end

    assign push = end_row;

    always_comb
    begin
        store_wr.en   = take;
        store_wr.bank = bank_reg;
        store_wr.idx  = fill_reg[IDX_W-1:0];
        store_wr.word = items.channel_word;
        store_wr.vol  = items.channel_volume;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (release_bank.valid)
        begin
            busy_next[release_bank.bank] = 1'b0;
        end
        if (end_row)
        begin
            busy_next[bank_reg] = 1'b1;
        end
        bank_next = end_row ? !bank_reg : bank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            level_reg     <= '0;
            loud_idx_reg  <= '0;
            loud_tone_reg <= '0;
            bass_cnt_reg  <= '0;
            bank_reg      <= 1'b0;
            busy_reg      <= '0;
        end
        else
        begin
            bank_reg <= bank_next;
            busy_reg <= busy_next;
            if (end_row)
            begin
                fill_reg      <= '0;
                level_reg     <= '0;
                loud_idx_reg  <= '0;
                loud_tone_reg <= '0;
                bass_cnt_reg  <= '0;
            end
            else
            begin
                fill_reg      <= fill_next;
                level_reg     <= level_next;
                loud_idx_reg  <= loud_idx_next;
                loud_tone_reg <= loud_tone_next;
                bass_cnt_reg  <= bass_cnt_next;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CHANNELS))
        else $error("fill count beyond channel count");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("row pushed into full queue");

    a_busy_bank: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.en |-> !busy_reg[store_wr.bank])
        else $error("write into bank still being emitted");

endmodule

// ===== hdl/bnm_queue.sv =====
// ----------------------------------------------------------------------------
// bnm_queue
// Short descriptor queue between front and back.
// ----------------------------------------------------------------------------
module bnm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bnm_pkg::row_desc_t push_desc,
    input  logic               pop,
    output bnm_pkg::row_desc_t head,
    output logic               full,
    output logic               empty
);
    import bnm_pkg::*;

    row_desc_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !empty)
        else $error("pushed descriptor lost");

endmodule

// ===== hdl/bnm_back.sv =====
// ----------------------------------------------------------------------------
// bnm_back
// Holds the row store, walks each queued row and emits its entries and the
// noise entry through an output register.
// ----------------------------------------------------------------------------
module bnm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               keep_quieter_bass,
    input  bnm_pkg::store_wr_t store_wr,
    input  logic               q_empty,
    input  bnm_pkg::row_desc_t q_head,
    output logic               pop,
    output bnm_pkg::bank_rel_t release_bank,
    bnm_out_if.source          results
);
    import bnm_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [VOL_W-1:0]  vol;
    } row_entry_t;

    row_entry_t store_mem [STORE_DEPTH];

    back_state_t       state_reg, state_next;
    row_desc_t         cur_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [TONE_W-1:0] prev_tone_reg, prev_tone_next;
    logic              first_row_reg, first_row_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0] out_channel_reg, out_channel_next;
    logic [WORD_W-1:0] out_word_reg, out_word_next;
    logic [VOL_W-1:0]  out_volume_reg, out_volume_next;
    logic              row_done_reg, row_done_next;

    logic              out_free;
    logic              load;
    logic              last_entry;
    logic              silence;
    logic [IDX_W:0]    rd_addr;
    row_entry_t        rd_entry;

    // read one entry ahead so the registered data matches idx_reg
    assign rd_addr = {(pop ? q_head.bank : cur_reg.bank), idx_next};

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_mem[{store_wr.bank, store_wr.idx}] <= '{word: store_wr.word,
                                                          vol:  store_wr.vol};
        end
        rd_entry <= store_mem[rd_addr];
    end

    assign out_free   = !out_valid_reg || results.ready;
    assign last_entry = (CNT_W'(idx_reg) + CNT_W'(1) == cur_reg.count);

    // moved channel, and other bass-looking channels on a conflict unless keep_quieter_bass
    assign silence = (cur_reg.found && idx_reg == cur_reg.loud_idx) ||
                     (cur_reg.conflict && !keep_quieter_bass &&
                      is_bass_word(rd_entry.word));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_ENTRY;
                end
            end
            BK_ENTRY:
            begin
                if (out_free && last_entry)
                begin
                    state_next = BK_NOISE;
                end
            end
            BK_NOISE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        pop               = 1'b0;
        load              = 1'b0;
        release_bank      = '{valid: 1'b0, bank: cur_reg.bank};
        idx_next          = idx_reg;
        prev_tone_next    = prev_tone_reg;
        first_row_next    = first_row_reg;
        out_channel_next  = out_channel_reg;
        out_word_next     = out_word_reg;
        out_volume_next   = out_volume_reg;
        row_done_next     = row_done_reg;
        case (state_reg)
            BK_IDLE:
            begin
                pop      = !q_empty;
                idx_next = '0;
            end
            BK_ENTRY:
            begin
                if (out_free)
                begin
                    load             = 1'b1;
                    idx_next         = idx_reg + IDX_W'(1);
                    out_channel_next = CHAN_W'(idx_reg);
                    out_word_next    = silence ? SILENT_WORD : rd_entry.word;
                    out_volume_next  = silence ? '0 : rd_entry.vol;
                    row_done_next    = 1'b0;
                end
            end
            BK_NOISE:
            begin
                if (out_free)
                begin
                    load               = 1'b1;
                    release_bank.valid = 1'b1;
                    first_row_next     = 1'b0;
                    out_channel_next   = CHAN_W'(CHANNELS);
                    row_done_next      = 1'b1;
                    if (cur_reg.found)
                    begin
                        out_word_next  = WORD_W'(cur_reg.noise_tone) | PERIODIC_FLAG;
                        if (first_row_reg || cur_reg.noise_tone != prev_tone_reg)
                        begin
                            out_word_next = out_word_next | TRIGGER_FLAG;
                        end
                        out_volume_next = cur_reg.loud_vol;
                        prev_tone_next  = cur_reg.noise_tone;
                    end
                    else
                    begin
                        out_word_next   = SILENT_WORD;
                        out_volume_next = '0;
                        prev_tone_next  = TONE_ONE;
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
        out_valid_next = load ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_head;
        end
        out_channel_reg <= out_channel_next;
        out_word_reg    <= out_word_next;
        out_volume_reg  <= out_volume_next;
        row_done_reg    <= row_done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            prev_tone_reg <= TONE_ONE;
            first_row_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            prev_tone_reg <= prev_tone_next;
            first_row_reg <= first_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_channel_reg;
    assign results.out_word    = out_word_reg;
    assign results.out_volume  = out_volume_reg;
    assign results.row_done    = row_done_reg;

    a_noise_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_NOISE && out_free) |=>
            (state_reg == BK_IDLE && out_valid_reg && row_done_reg))
        else $error("noise word not last of row");

    a_idx_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ENTRY) |-> (CNT_W'(idx_reg) < cur_reg.count))
        else $error("entry index past row length");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |=> $stable(out_word_reg))
        else $error("pending result overwritten");

endmodule

// ===== hdl/bass_to_periodic_noise_mover.sv =====
// ----------------------------------------------------------------------------
// bass_to_periodic_noise_mover
// Moves the loudest bass channel of each tick row to a periodic noise entry.
// ----------------------------------------------------------------------------
//  port        dir   handshake        word
//  items       in    valid/ready      channel_word, channel_volume, row_end
//  results     out   valid/ready      out_channel, out_word, out_volume, row_done
//  cfg_we      in    write enable     cfg_wdata = keep_quieter_bass
//
//  entries are taken one per cycle into one of two row banks
//  a row of n stored entries gives n+1 words, one per ready cycle, then idles
//  the next row fills the other bank meanwhile; input stalls while both are busy
//  the output register holds its word until results.ready
//  reset clears all control state; no clearing pass is needed
// ----------------------------------------------------------------------------
module bass_to_periodic_noise_mover (
    input  logic       clk,
    input  logic       rst_n,
    bnm_in_if.sink     items,
    bnm_out_if.source  results,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);
    import bnm_pkg::*;

    logic       keep_reg;
    store_wr_t  store_wr;
    bank_rel_t  release_bank;
    row_desc_t  push_desc;
    row_desc_t  q_head;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            keep_reg <= cfg_wdata;
        end
    end

    bnm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (items),
        .q_full       (q_full),
        .release_bank (release_bank),
        .store_wr     (store_wr),
        .push         (push),
        .push_desc    (push_desc)
    );

    bnm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    bnm_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .keep_quieter_bass (keep_reg),
        .store_wr          (store_wr),
        .q_empty           (q_empty),
        .q_head            (q_head),
        .pop               (pop),
        .release_bank      (release_bank),
        .results           (results)
    );

endmodule
